### design/page_framebuffer_draw_engine_top_defines.svh
// Assertion macros used by the checker file.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PFDE_ASSERT_NOW(lbl, ck, rn, ant, con, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PFDE_ASSERT_NEXT(lbl, ck, rn, ant, con, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
    else $error(msg);

`endif

### design/pfde_pkg.sv
`default_nettype none

package pfde_pkg;

  // coordinate width: holds -4096..4095 signed
  localparam int CW    = 13;
  // byte index inside one buffer, and index plus buffer offset
  localparam int IDX_W = 17;
  localparam int SUM_W = 18;

  localparam logic [2:0] KIND_SET_PIXEL  = 3'd0;
  localparam logic [2:0] KIND_FILL_RECT  = 3'd1;
  localparam logic [2:0] KIND_BLIT_BEGIN = 3'd2;
  localparam logic [2:0] KIND_BLIT_BYTE  = 3'd3;
  localparam logic [2:0] KIND_SWAP       = 3'd4;
  localparam logic [2:0] KIND_READ_FRONT = 3'd5;

  // pixel source for the read-modify-write
  localparam logic [1:0] SRC_ITEM = 2'd0;
  localparam logic [1:0] SRC_FILL = 2'd1;
  localparam logic [1:0] SRC_BLIT = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [9:0]        read_index;
    logic [7:0]        data_byte;
    logic              msb_first;
    logic              pixel_on;
    logic [9:0]        area_height;
    logic [9:0]        area_width;
    logic signed [10:0] pos_y;
    logic signed [10:0] pos_x;
  } item_t;

  typedef struct packed {
    logic       clr_step;
    logic       load_item;
    logic       fill_init;
    logic       fill_adv;
    logic       blit_begin;
    logic       byte_start;
    logic       blit_adv;
    logic       pix_rd;
    logic       pix_wr;
    logic       swap;
    logic       front_rd;
    logic       out_load;
    logic       out_status;
    logic [1:0] src;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [2:0] kind;
    logic       blit_live;
    logic       fill_empty;
    logic       fill_last;
    logic       blit_end;
    logic       bit_last;
  } stat_t;

endpackage

`default_nettype wire

### design/page_framebuffer_draw_engine_top.sv
// Double-buffered monochrome page framebuffer with a drawing engine. Pixel
// (x, y) sits in byte x + (y/8)*SCREEN_WIDTH at bit y mod 8; both buffers
// live in one memory of 2*FRAME_BYTES bytes, the draw buffer at offset
// draw_select*FRAME_BYTES. After reset the engine clears the whole memory,
// one byte per cycle, with in_tready low until the clear is done. Then one
// word is processed at a time. Every pixel is a read-modify-write through the
// single memory (address and read, then merge and write); a bitmap byte
// draws at most 8 pixels and a fill draws every clipped pixel. A result sits
// in an output register, so the next word is taken while the previous result
// still waits on out_tready.
`default_nettype none

module page_framebuffer_draw_engine_top import pfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int FRAME_BYTES   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pos_x[10:0], pos_y[21:11], area_width[31:22], area_height[41:32],
  // pixel_on[42], msb_first[43], data_byte[51:44], read_index[61:52], zero[63:62]
  input  wire logic [63:0] in_tdata,
  // kind[2:0]
  input  wire logic [2:0]  in_tuser,
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_data[7:0], blit_busy[8], zero[15:9]
  output logic [15:0]      out_tdata,
  // status[0]
  output logic             out_tuser
);

  item_t      item;
  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] read_data;
  logic       status;
  logic       blit_busy;

  // kind rides in tuser, the rest of the command in tdata
  assign item = item_t'({in_tuser, in_tdata[61:0]});

  pfde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfde_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_in   (item),
    .cmd       (cmd),
    .stat      (stat),
    .read_data (read_data),
    .status    (status),
    .blit_busy (blit_busy)
  );

  assign out_tdata = {7'd0, blit_busy, read_data};
  assign out_tuser = status;

endmodule

`default_nettype wire

### design/pfde_ram.sv
`default_nettype none

module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/pfde_datapath.sv
`default_nettype none

module pfde_datapath import pfde_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int FRAME_BYTES   = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t item_in,
  input  wire cmd_t  cmd,
  output stat_t      stat,
  output logic [7:0] read_data,
  output logic       status,
  output logic       blit_busy
);

  localparam int AW = $clog2(2 * FRAME_BYTES);
  localparam logic signed [CW-1:0] SW_S = CW'(SCREEN_WIDTH);
  localparam logic signed [CW-1:0] SH_S = CW'(SCREEN_HEIGHT);
  localparam logic [SUM_W-1:0] FB_U = SUM_W'(FRAME_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(2 * FRAME_BYTES - 1);

  item_t item_r;
  logic  draw_sel_r;
  logic [AW-1:0] clr_cnt_r;

  // fill walk
  logic signed [CW-1:0] fx_r, fy_r, fx0_r, fx1_r, fy1_r;
  logic fill_empty_r;

  // blit
  logic signed [CW-1:0] cx_r, cy_r, ox_r, oy_r;
  logic [9:0]  bw_r, bh_r;
  logic        border_r;
  logic [16:0] bleft_r;
  logic        live_r;
  logic [2:0]  bit_r;

  // pixel in flight
  logic [AW-1:0] paddr_r;
  logic [7:0]    pmask_r;
  logic          pvalid_r;
  logic          pon_r;
  logic          rvalid_r;

  logic [7:0] out_data_r;
  logic       out_status_r;
  logic       out_busy_r;

  // ---- fill bounds
  logic signed [CW-1:0] px_e, py_e, wx, hy, xe, ye, fx0, fy0, fx1, fy1;
  logic row_last;

  assign px_e = CW'(item_r.pos_x);
  assign py_e = CW'(item_r.pos_y);
  assign wx   = $signed({{(CW-10){1'b0}}, item_r.area_width});
  assign hy   = $signed({{(CW-10){1'b0}}, item_r.area_height});
  assign xe   = px_e + wx;
  assign ye   = py_e + hy;
  assign fx0  = (px_e < 13'sd0) ? 13'sd0 : px_e;
  assign fy0  = (py_e < 13'sd0) ? 13'sd0 : py_e;
  assign fx1  = (xe > SW_S) ? SW_S : xe;
  assign fy1  = (ye > SH_S) ? SH_S : ye;
  assign row_last = (fx_r == fx1_r - 13'sd1);

  // ---- blit cursor step
  logic signed [CW-1:0] nx, cx_nxt, cy_nxt;
  logic row_end, blit_end;
  logic [2:0] bsel;
  logic       bon;
  logic [19:0] area;
  logic [16:0] bl_init;

  assign nx      = cx_r + 13'sd1;
  assign row_end = ((nx - ox_r) == $signed({3'b000, bw_r}));
  assign cx_nxt  = row_end ? ox_r : nx;
  assign cy_nxt  = row_end ? (cy_r + 13'sd1) : cy_r;
  assign blit_end = ((cy_nxt - oy_r) == $signed({3'b000, bh_r})) || (cy_nxt >= SH_S);
  assign bsel    = border_r ? (3'd7 - bit_r) : bit_r;
  assign bon     = item_r.data_byte[bsel];
  assign area    = 20'(item_r.area_width) * 20'(item_r.area_height);
  assign bl_init = area[19:3];

  // ---- pixel address
  logic signed [CW-1:0] sx, sy;
  logic son, onscreen, pvalid;
  logic [SUM_W-1:0] idx, pa_sum, fidx, fa_sum;
  logic [AW-1:0] paddr, faddr;
  logic fvalid;

  always_comb begin
    unique case (cmd.src)
      SRC_FILL: begin
        sx = fx_r; sy = fy_r; son = item_r.pixel_on;
      end
      SRC_BLIT: begin
        sx = cx_r; sy = cy_r; son = bon;
      end
      default: begin
        sx = px_e; sy = py_e; son = item_r.pixel_on;
      end
    endcase
  end

  assign onscreen = (sx >= 13'sd0) && (sx < SW_S) && (sy >= 13'sd0) && (sy < SH_S);
  assign idx = SUM_W'(sx[9:0]) + SUM_W'(IDX_W'(sy[9:3]) * IDX_W'(SCREEN_WIDTH));
  assign pvalid = onscreen && (idx < FB_U);
  assign pa_sum = draw_sel_r ? (idx + FB_U) : idx;
  assign paddr  = pa_sum[AW-1:0];

  // front buffer is the one not drawn into
  assign fidx   = SUM_W'(item_r.read_index);
  assign fvalid = (fidx < FB_U);
  assign fa_sum = draw_sel_r ? fidx : (fidx + FB_U);
  assign faddr  = fa_sum[AW-1:0];

  // ---- memory
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata, rmw;

  assign rmw       = pon_r ? (ram_rdata | pmask_r) : (ram_rdata & ~pmask_r);
  assign ram_we    = cmd.clr_step || (cmd.pix_wr && pvalid_r);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : paddr_r;
  assign ram_wdata = cmd.clr_step ? 8'd0 : rmw;
  assign ram_re    = cmd.front_rd || cmd.pix_rd;
  assign ram_raddr = cmd.front_rd ? faddr : paddr;

  pfde_ram #(
    .WIDTH (8),
    .DEPTH (2 * FRAME_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- control-visible state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_sel_r <= 1'b0;
      clr_cnt_r  <= '0;
      live_r     <= 1'b0;
      bleft_r    <= '0;
      cx_r       <= '0;
      cy_r       <= '0;
      ox_r       <= '0;
      oy_r       <= '0;
      bw_r       <= '0;
      bh_r       <= '0;
      border_r   <= 1'b0;
      bit_r      <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.swap) begin
        draw_sel_r <= ~draw_sel_r;
      end
      if (cmd.byte_start) begin
        bit_r <= '0;
      end
      if (cmd.blit_begin) begin
        ox_r     <= px_e;
        oy_r     <= py_e;
        cx_r     <= px_e;
        cy_r     <= py_e;
        bw_r     <= item_r.area_width;
        bh_r     <= item_r.area_height;
        border_r <= item_r.msb_first;
        bleft_r  <= bl_init;
        live_r   <= (bl_init != 17'd0);
      end else if (cmd.blit_adv) begin
        cx_r  <= cx_nxt;
        cy_r  <= cy_nxt;
        bit_r <= bit_r + 3'd1;
        if (blit_end) begin
          live_r  <= 1'b0;
          bleft_r <= '0;
        end else if (bit_r == 3'd7) begin
          if (bleft_r != 17'd0) begin
            bleft_r <= bleft_r - 17'd1;
          end
          if (bleft_r <= 17'd1) begin
            live_r <= 1'b0;
          end
        end
      end
    end
  end

  // ---- payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= item_in;
    end
    if (cmd.fill_init) begin
      fx_r         <= fx0;
      fy_r         <= fy0;
      fx0_r        <= fx0;
      fx1_r        <= fx1;
      fy1_r        <= fy1;
      fill_empty_r <= (fx1 <= fx0) || (fy1 <= fy0);
    end else if (cmd.fill_adv) begin
      if (row_last) begin
        fx_r <= fx0_r;
        fy_r <= fy_r + 13'sd1;
      end else begin
        fx_r <= fx_r + 13'sd1;
      end
    end
    if (cmd.pix_rd) begin
      paddr_r  <= paddr;
      pmask_r  <= 8'b1 << sy[2:0];
      pvalid_r <= pvalid;
      pon_r    <= son;
    end
    if (cmd.front_rd) begin
      rvalid_r <= fvalid;
    end
    if (cmd.out_load) begin
      out_data_r   <= ((item_r.kind == KIND_READ_FRONT) && rvalid_r) ? ram_rdata : 8'd0;
      out_status_r <= cmd.out_status;
      out_busy_r   <= live_r;
    end
  end

  assign stat.clr_last   = (clr_cnt_r == CLR_LAST);
  assign stat.kind       = item_r.kind;
  assign stat.blit_live  = live_r;
  assign stat.fill_empty = fill_empty_r;
  assign stat.fill_last  = row_last && (fy_r == fy1_r - 13'sd1);
  assign stat.blit_end   = blit_end;
  assign stat.bit_last   = (bit_r == 3'd7);

  assign read_data = out_data_r;
  assign status    = out_status_r;
  assign blit_busy = out_busy_r;

endmodule

`default_nettype wire

### design/pfde_ctrl.sv
`default_nettype none

module pfde_ctrl import pfde_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DISP = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_PRD  = 3'd4;
  localparam logic [2:0] S_PWR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_SPARE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] src_r, src_nxt;
  logic       ign_r, ign_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    ign_nxt       = ign_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.src       = src_r;
    cmd.out_status = ign_r;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        ign_nxt   = 1'b0;
        state_nxt = S_DONE;
        unique case (stat.kind)
          KIND_SET_PIXEL: begin
            src_nxt   = SRC_ITEM;
            state_nxt = S_PRD;
          end
          KIND_FILL_RECT: begin
            cmd.fill_init = 1'b1;
            src_nxt       = SRC_FILL;
            state_nxt     = S_FILL;
          end
          KIND_BLIT_BEGIN: begin
            cmd.blit_begin = 1'b1;
          end
          KIND_BLIT_BYTE: begin
            if (stat.blit_live) begin
              cmd.byte_start = 1'b1;
              src_nxt        = SRC_BLIT;
              state_nxt      = S_PRD;
            end else begin
              ign_nxt = 1'b1;
            end
          end
          KIND_SWAP: begin
            cmd.swap = 1'b1;
          end
          KIND_READ_FRONT: begin
            cmd.front_rd = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_FILL: begin
        state_nxt = stat.fill_empty ? S_DONE : S_PRD;
      end
      S_PRD: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = S_PWR;
      end
      S_PWR: begin
        cmd.pix_wr = 1'b1;
        unique case (src_r)
          SRC_FILL: begin
            cmd.fill_adv = 1'b1;
            state_nxt    = stat.fill_last ? S_DONE : S_PRD;
          end
          SRC_BLIT: begin
            cmd.blit_adv = 1'b1;
            state_nxt    = (stat.blit_end || stat.bit_last) ? S_DONE : S_PRD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SPARE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      src_r       <= SRC_ITEM;
      ign_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_r       <= src_nxt;
      ign_r       <= ign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### design/pfde_checker.sv
`default_nettype none
`include "page_framebuffer_draw_engine_top_defines.svh"

module pfde_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // a stalled result word holds
  `PFDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // one word at a time: busy right after an accept
  `PFDE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted back to back")

  // an ignored bitmap byte never reports data or a live blit
  `PFDE_ASSERT_NOW(a_ignored_clean, clk, rst_n, out_tvalid && out_tuser, out_tdata[8:0] == 9'd0, "ignored byte with data or busy")

  // memory clear runs first after reset
  `PFDE_ASSERT_NOW(a_clear_after_reset, clk, rst_n, $rose(rst_n), !in_tready && !out_tvalid, "ready during clear")

endmodule

bind page_framebuffer_draw_engine_top pfde_checker u_pfde_checker (.*);

`default_nettype wire
